// ===== hdl/robin_hood_hash_set_unit_macros.svh =====
// assertion macros for the robin hood hash set unit
// used by the checker; expects clk_i and rst_ni in scope
`ifndef ROBIN_HOOD_HASH_SET_UNIT_MACROS_SVH
`define ROBIN_HOOD_HASH_SET_UNIT_MACROS_SVH

// same-cycle implication
`define RHHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhhs check failed");

// next-cycle implication
`define RHHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhhs check failed");

`endif

// ===== hdl/rhhs_pkg.sv =====
// shared types and constants of the robin hood hash set unit
// no dependencies
`timescale 1ns / 1ps

package rhhs_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int KEY_BITS  = 31;
  localparam int HOME_W    = 10;
  localparam int SLOT_W    = 10;
  localparam int CFG_W     = 11;
  localparam int BC_RESET  = 1024;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KEY_BITS-1:0] key;
    logic [HOME_W-1:0]   home_bucket;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

endpackage

// ===== hdl/rhhs_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module rhhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/robin_hood_hash_set_unit.sv =====
// robin hood hash set unit: linear probing, backward-shift removal
// depends on rhhs_pkg and rhhs_ram
`timescale 1ns / 1ps

// Usage
//   input channel in_valid_i/in_ready_o carries one word: opcode, key and
//   the key's home bucket (hash done outside). output channel
//   out_valid_o/out_ready_i returns one word per input: status and slot.
//   cfg_we_i/cfg_data_i writes bucket_count; any write empties the table.
// Operation
//   an operation first reduces the home bucket modulo bucket_count
//   (one remainder bit per cycle), then probes slot by slot, since every
//   probe is a read of the single table ram followed by a compare step;
//   remove then shifts entries back, a read and a write step per entry,
//   ending in a write that clears the last slot; insert walks the run
//   again while placing, a read and a check per slot walked.
//   one operation is in flight at a time; in_ready_o is high only when idle.
// Reset and stalls
//   after reset and after every bucket_count write the unit sweeps all
//   SLOTS table entries, clearing valid flags; in_ready_o stays low then.
//   a result waits in the output register while out_ready_i is low; the
//   next operation may start, but its result is held until that clears.

module robin_hood_hash_set_unit
  import rhhs_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rhhs_pkg::in_word_t     in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rhhs_pkg::out_word_t    out_word_o,
  input  logic                   cfg_we_i,
  input  logic [rhhs_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = 1 + KEY_BITS + IW;
  localparam int NW = $clog2(HOME_W);
  localparam int BC_INIT = (BC_RESET > SLOTS) ? SLOTS : BC_RESET;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_FRD  = 4'd3;
  localparam logic [3:0] S_FCHK = 4'd4;
  localparam logic [3:0] S_PRD  = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_DRD  = 4'd7;
  localparam logic [3:0] S_DCHK = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [IW-1:0]       clr_q, clr_d;
  logic [CW-1:0]       bc_q, bc_d;
  logic [CW-1:0]       occ_q, occ_d;
  logic [1:0]          op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [IW-1:0]       home_q, home_d;
  logic [HOME_W-1:0]   raw_q, raw_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic [NW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       d_q, d_d;
  logic [IW-1:0]       s_q, s_d;
  logic [IW-1:0]       first_q, first_d;
  logic                placed_q, placed_d;
  logic [1:0]          rst_st_q, rst_st_d;
  logic [IW-1:0]       rslot_q, rslot_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_word_q, out_word_d;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [MW-1:0]       ram_wdata, ram_rdata;
  logic                r_valid;
  logic [KEY_BITS-1:0] r_key;
  logic [IW-1:0]       r_home;

  logic [CW-1:0]       sp1;
  logic [IW-1:0]       nx;
  logic [IW-1:0]       dist_s;
  logic [CW:0]         dist_w;
  logic [CW-1:0]       dres;
  logic [CW:0]         mod_t;
  logic [CW:0]         mod_r;
  logic [31:0]         cfg_v;

  rhhs_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign r_valid = ram_rdata[MW-1];
  assign r_key   = ram_rdata[IW +: KEY_BITS];
  assign r_home  = ram_rdata[IW-1:0];

  // next slot with wrap at bucket_count
  assign sp1 = CW'(s_q) + CW'(1);
  assign nx  = (sp1 == bc_q) ? '0 : IW'(sp1);

  assign ram_raddr = (state_q == S_DRD) ? nx : s_q;

  // shared distance unit: (slot - home) mod bucket_count
  assign dist_s = (state_q == S_DCHK) ? nx : s_q;
  always_comb begin
    if (dist_s >= r_home) begin
      dist_w = {1'b0, CW'(dist_s)} - {1'b0, CW'(r_home)};
    end else begin
      dist_w = {1'b0, CW'(dist_s)} + {1'b0, bc_q} - {1'b0, CW'(r_home)};
    end
  end
  assign dres = CW'(dist_w);

  // restoring remainder step, one home bit per cycle
  assign mod_t = {rem_q, raw_q[HOME_W-1]};
  assign mod_r = (mod_t >= {1'b0, bc_q}) ? (mod_t - {1'b0, bc_q}) : mod_t;

  assign cfg_v = 32'(cfg_data_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bc_d        = bc_q;
    occ_d       = occ_q;
    op_d        = op_q;
    key_d       = key_q;
    home_d      = home_q;
    raw_d       = raw_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    d_d         = d_q;
    s_d         = s_q;
    first_d     = first_q;
    placed_d    = placed_q;
    rst_st_d    = rst_st_q;
    rslot_d     = rslot_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    ram_we      = 1'b0;
    ram_waddr   = s_q;
    ram_wdata   = {1'b1, key_q, home_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + IW'(1);
        if (clr_q == IW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_word_i.opcode;
          key_d   = in_word_i.key;
          raw_d   = in_word_i.home_bucket;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        rem_d = CW'(mod_r);
        raw_d = {raw_q[HOME_W-2:0], 1'b0};
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(HOME_W - 1)) begin
          home_d = IW'(mod_r);
          s_d    = IW'(mod_r);
          d_d    = '0;
          if (op_q == OP_INSERT || op_q == OP_LOOKUP || op_q == OP_REMOVE) begin
            state_d = S_FRD;
          end else begin
            rst_st_d = ST_MISS;
            rslot_d  = '0;
            state_d  = S_FIN;
          end
        end
      end
      S_FRD: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (r_valid && !(dres < d_q) && r_key == key_q) begin
          rslot_d = s_q;
          case (op_q)
            OP_INSERT: begin
              rst_st_d = ST_DUP;
              state_d  = S_FIN;
            end
            OP_REMOVE: begin
              rst_st_d = ST_DONE;
              d_d      = '0;
              state_d  = S_DRD;
            end
            default: begin
              rst_st_d = ST_DONE;
              state_d  = S_FIN;
            end
          endcase
        end else if (r_valid && !(dres < d_q) && (d_q + CW'(1)) != bc_q) begin
          s_d     = nx;
          d_d     = d_q + CW'(1);
          state_d = S_FRD;
        end else begin
          // key absent
          rslot_d = '0;
          if (op_q == OP_INSERT) begin
            if (occ_q >= bc_q) begin
              rst_st_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              s_d      = home_q;
              d_d      = '0;
              placed_d = 1'b0;
              state_d  = S_PRD;
            end
          end else begin
            rst_st_d = ST_MISS;
            state_d  = S_FIN;
          end
        end
      end
      S_PRD: begin
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (!r_valid) begin
          ram_we   = 1'b1;
          occ_d    = occ_q + CW'(1);
          rst_st_d = ST_DONE;
          rslot_d  = placed_q ? first_q : s_q;
          state_d  = S_FIN;
        end else begin
          if (dres < d_q) begin
            // resident is richer: swap and carry it on
            ram_we   = 1'b1;
            key_d    = r_key;
            home_d   = r_home;
            d_d      = dres + CW'(1);
            placed_d = 1'b1;
            if (!placed_q) begin
              first_d = s_q;
            end
          end else begin
            d_d = d_q + CW'(1);
          end
          s_d     = nx;
          state_d = S_PRD;
        end
      end
      S_DRD: begin
        state_d = S_DCHK;
      end
      S_DCHK: begin
        ram_we = 1'b1;
        if (!r_valid || dres == '0 || d_q == bc_q) begin
          ram_wdata = '0;
          if (occ_q != '0) begin
            occ_d = occ_q - CW'(1);
          end
          state_d = S_FIN;
        end else begin
          ram_wdata = ram_rdata;
          s_d       = nx;
          d_d       = d_q + CW'(1);
          state_d   = S_DRD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_word_d.status = rst_st_q;
          out_word_d.slot   = SLOT_W'(rslot_q);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
        clr_d   = '0;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_v == 32'd0) begin
        bc_d = CW'(1);
      end else if (cfg_v > 32'(SLOTS)) begin
        bc_d = CW'(SLOTS);
      end else begin
        bc_d = CW'(cfg_v);
      end
      occ_d   = '0;
      clr_d   = '0;
      state_d = S_CLR;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      bc_q        <= CW'(BC_INIT);
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      placed_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bc_q        <= bc_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      placed_q    <= placed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    home_q     <= home_d;
    raw_q      <= raw_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    d_q        <= d_d;
    s_q        <= s_d;
    first_q    <= first_d;
    rst_st_q   <= rst_st_d;
    rslot_q    <= rslot_d;
    out_word_q <= out_word_d;
  end

endmodule

// ===== hdl/rhhs_checker.sv =====
// port-level checker for the robin hood hash set unit, with its bind
// depends on rhhs_pkg and robin_hood_hash_set_unit_macros.svh
`timescale 1ns / 1ps
`include "robin_hood_hash_set_unit_macros.svh"

module rhhs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input rhhs_pkg::out_word_t        out_word_o,
  input logic                       cfg_we_i
);
  import rhhs_pkg::*;

  // stalled result word holds
  `RHHS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o))

  // one operation at a time: busy right after taking a word
  `RHHS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // failures carry slot zero
  `RHHS_ASSERT_NOW(a_full_slot, out_valid_o && out_word_o.status == ST_FULL, out_word_o.slot == '0)
  `RHHS_ASSERT_NOW(a_miss_slot, out_valid_o && out_word_o.status == ST_MISS, out_word_o.slot == '0)

  // a bucket_count write starts the clearing sweep
  `RHHS_ASSERT_NEXT(a_cfg_clears, cfg_we_i, !in_ready_o)

endmodule

bind robin_hood_hash_set_unit rhhs_checker u_rhhs_checker (.*);

// ===== bench/robin_hood_hash_set_unit_tb.sv =====
// self-checking bench for the robin hood hash set unit
// depends on rhhs_pkg and the unit's rtl; a scoreboard class predicts each result word
`timescale 1ns / 1ps

module robin_hood_hash_set_unit_tb;
  import rhhs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;

  class hash_set_scoreboard;
    logic [KEY_BITS-1:0] tbl_key[SLOTS_DEF];
    int unsigned tbl_home[SLOTS_DEF];
    bit tbl_valid[SLOTS_DEF];
    int unsigned occupancy;
    int unsigned buckets;
    out_word_t expected_words[$];
    int mismatches;
    int checked;

    function new();
      buckets = BC_RESET;
      clear_table();
    endfunction

    function void clear_table();
      foreach (tbl_valid[i]) tbl_valid[i] = 0;
      occupancy = 0;
    endfunction

    function void set_buckets(logic [CFG_W-1:0] v);
      buckets = (v == 0) ? 1 : (v > SLOTS_DEF) ? SLOTS_DEF : v;
      clear_table();
    endfunction

    function int unsigned probe_dist(int unsigned s, int unsigned h);
      return (s + buckets - h) % buckets;
    endfunction

    function bit find_key(logic [KEY_BITS-1:0] k, int unsigned h, output int unsigned where);
      int unsigned s;
      where = 0;
      for (int unsigned d = 0; d < buckets; d++) begin
        s = (h + d) % buckets;
        if (!tbl_valid[s]) return 0;
        if (probe_dist(s, tbl_home[s]) < d) return 0;
        if (tbl_key[s] == k) begin
          where = s;
          return 1;
        end
      end
      return 0;
    endfunction

    // carried entry swaps with any resident nearer its own home
    function int unsigned place_key(logic [KEY_BITS-1:0] k, int unsigned h);
      logic [KEY_BITS-1:0] ck, tk;
      int unsigned ch, th, s, first;
      bit placed;
      ck = k;
      ch = h;
      first = 0;
      placed = 0;
      for (int unsigned d = 0; d < buckets; d++) begin
        s = (h + d) % buckets;
        if (!tbl_valid[s]) begin
          tbl_valid[s] = 1;
          tbl_key[s] = ck;
          tbl_home[s] = ch;
          if (!placed) first = s;
          break;
        end
        if (probe_dist(s, tbl_home[s]) < probe_dist(s, ch)) begin
          tk = tbl_key[s];
          th = tbl_home[s];
          tbl_key[s] = ck;
          tbl_home[s] = ch;
          ck = tk;
          ch = th;
          if (!placed) begin
            first = s;
            placed = 1;
          end
        end
      end
      occupancy++;
      return first;
    endfunction

    function void shift_back(int unsigned idx);
      int unsigned nx;
      for (int unsigned n = 0; n < buckets; n++) begin
        nx = (idx + 1) % buckets;
        if (!tbl_valid[nx] || probe_dist(nx, tbl_home[nx]) == 0) break;
        tbl_key[idx] = tbl_key[nx];
        tbl_home[idx] = tbl_home[nx];
        idx = nx;
      end
      tbl_valid[idx] = 0;
      if (occupancy > 0) occupancy--;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      int unsigned h, where;
      bit hit;
      h = w.home_bucket % buckets;
      r.status = ST_MISS;
      r.slot = '0;
      case (w.opcode)
        OP_INSERT: begin
          hit = find_key(w.key, h, where);
          if (hit) begin
            r.status = ST_DUP;
            r.slot = SLOT_W'(where);
          end else if (occupancy >= buckets) begin
            r.status = ST_FULL;
          end else begin
            r.slot = SLOT_W'(place_key(w.key, h));
            r.status = ST_DONE;
          end
        end
        OP_LOOKUP: begin
          if (find_key(w.key, h, where)) begin
            r.status = ST_DONE;
            r.slot = SLOT_W'(where);
          end
        end
        OP_REMOVE: begin
          if (find_key(w.key, h, where)) begin
            shift_back(where);
            r.status = ST_DONE;
            r.slot = SLOT_W'(where);
          end
        end
        default: ;
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d slot %0d", got.status, got.slot);
        return;
      end
      exp_w = expected_words.pop_front();
      checked++;
      if (got.status !== exp_w.status || got.slot !== exp_w.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: status exp %0d got %0d, slot exp %0d got %0d",
                   $realtime, exp_w.status, got.status, exp_w.slot, got.slot);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, cfg_we_i;
  in_word_t in_word_i;
  out_word_t out_word_o;
  logic [CFG_W-1:0] cfg_data_i;

  hash_set_scoreboard sb;
  bit no_idle, hold_req;
  int hold_left, cycles, words_sent, settings_used;

  logic [KEY_BITS-1:0] pool_key[64];
  logic [HOME_W-1:0] pool_home[64];
  int pool_n;

  robin_hood_hash_set_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_word_o);
  end

  task automatic send_word(logic [1:0] op, logic [KEY_BITS-1:0] k, logic [HOME_W-1:0] h);
    in_word_t w;
    w.opcode = op;
    w.key = k;
    w.home_bucket = h;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    words_sent++;
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_write(logic [CFG_W-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_buckets(v);
    settings_used++;
  endtask

  // key pool with clustered homes so probe runs get long and wrap
  task automatic fill_pool(int n, int unsigned span);
    int unsigned base;
    base = $urandom_range(0, 1023);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      pool_key[i] = KEY_BITS'($urandom());
      pool_home[i] = HOME_W'((base + $urandom_range(0, span)) % 1024);
    end
  endtask

  task automatic random_phase(int count);
    int idx, r;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 45) ? OP_INSERT : (r < 70) ? OP_LOOKUP : (r < 96) ? OP_REMOVE : OP_UNUSED;
      if ($urandom_range(0, 99) < 85) begin
        idx = $urandom_range(0, pool_n - 1);
        send_word(op, pool_key[idx], pool_home[idx]);
      end else begin
        send_word(op, KEY_BITS'($urandom()), HOME_W'($urandom()));
      end
    end
  endtask

  initial begin
    int unsigned bc_list[7] = '{1, 2, 5, 16, 64, 1024, 3};
    sb = new();
    rst_ni = 0;
    in_valid_i = 0;
    in_word_i = '0;
    out_ready_i = 0;
    cfg_we_i = 0;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // extremes and wraparound at the default size
    send_word(OP_INSERT, '0, '0);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_INSERT, 31'd5, 10'd1023);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_LOOKUP, '1, '1);
    send_word(OP_INSERT, 31'd5, 10'd1023);
    send_word(OP_REMOVE, 31'd5, 10'd1023);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_REMOVE, 31'd77, 10'd3);
    send_word(OP_LOOKUP, 31'd77, 10'd3);
    send_word(OP_UNUSED, '1, '1);
    send_word(OP_REMOVE, '1, '1);

    // zero count acts as one: full table and out-of-range homes
    drain_and_write('0);
    send_word(OP_INSERT, 31'h2aaaaaaa, 10'd700);
    send_word(OP_INSERT, 31'h55555555, 10'd0);
    send_word(OP_LOOKUP, 31'h2aaaaaaa, 10'd3);
    send_word(OP_REMOVE, 31'h2aaaaaaa, 10'd9);
    send_word(OP_INSERT, 31'h55555555, 10'd1023);

    // oversize count saturates
    drain_and_write('1);
    send_word(OP_INSERT, 31'd9, 10'd1023);
    send_word(OP_LOOKUP, 31'd9, 10'd1023);

    foreach (bc_list[p]) begin
      drain_and_write(CFG_W'(bc_list[p]));
      fill_pool((bc_list[p] + 3 > 40) ? 40 : bc_list[p] + 3, (bc_list[p] > 16) ? 8 : 1023);
      no_idle = (p == 4);
      if (p == 5) hold_req = 1;
      random_phase(68);
    end
    no_idle = 0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d words sent over %0d table sizes, %0d results checked, %0d mismatches",
             words_sent, settings_used + 1, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== robin_hood_hash_set_unit.f =====
+incdir+hdl
hdl/rhhs_pkg.sv
hdl/rhhs_ram.sv
hdl/robin_hood_hash_set_unit.sv
hdl/rhhs_checker.sv
bench/robin_hood_hash_set_unit_tb.sv
